// ===== hw/rtl/trimmed_mean_current_sensor_core_macros.svh =====
// Assertion macros for the trimmed mean current sensor core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TRIMMED_MEAN_CURRENT_SENSOR_CORE_MACROS_SVH
`define TRIMMED_MEAN_CURRENT_SENSOR_CORE_MACROS_SVH

// same-cycle implication
`define TMCS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmcs assertion failed");

// next-cycle implication
`define TMCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmcs assertion failed");

`endif

// ===== hw/rtl/tmcs_pkg.sv =====
// Constants and widths for the trimmed mean current sensor core.
// No dependencies.
package tmcs_pkg;

    localparam int WINDOW   = 16;
    localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LEVEL_W  = 10;
    localparam int MA_W     = 17;

    localparam int LO_RAW   = (WINDOW * 15) / 100;
    localparam int LO       = (LO_RAW < 1) ? 1 : LO_RAW;
    localparam int HI_RAW   = (WINDOW * 85) / 100 + 1;
    localparam int HI       = (HI_RAW > WINDOW - 1) ? WINDOW - 1 : HI_RAW;
    localparam int N_KEEP   = HI - LO;

    localparam int ADC_SPAN = 1023;
    localparam int MA_SCALE = 125000;

    localparam int SUM_W    = $clog2(WINDOW * ADC_SPAN + 1);

    // mean: sum / N_KEEP == (sum * ceil(2^s / N_KEEP)) >> s for any SUM_W-bit sum
    localparam int     KEEP_LOG   = $clog2(N_KEEP);
    localparam int     MEAN_SHIFT = SUM_W + KEEP_LOG;
    localparam longint MEAN_MUL   = ((longint'(1) << MEAN_SHIFT) + longint'(N_KEEP) - 1)
                                    / longint'(N_KEEP);

    // current: diff * MA_SCALE / ADC_SPAN folded into one constant; 2^s > ADC_SPAN^2 keeps
    // the rounding error below one step of diff * MA_SCALE / ADC_SPAN
    localparam int     MA_SHIFT   = 2 * LEVEL_W + 1;
    localparam longint MA_MUL     = ((longint'(MA_SCALE) << MA_SHIFT) + longint'(ADC_SPAN) - 1)
                                    / longint'(ADC_SPAN);

    localparam int MUL_B_W  = ($clog2(MA_MUL + 1) > $clog2(MEAN_MUL + 1)) ?
                              $clog2(MA_MUL + 1) : $clog2(MEAN_MUL + 1);
    localparam int MUL_P_W  = SUM_W + MUL_B_W;

    localparam logic [LEVEL_W-1:0] ZERO_LEVEL_RST = LEVEL_W'(511);

endpackage

// ===== hw/rtl/trimmed_mean_current_sensor_core.sv =====
// Trimmed mean current sensor core: ring window, streaming sorted list, shared multiplier.
// Depends on tmcs_pkg and trimmed_mean_current_sensor_core_macros.svh.
// From accept to m_tvalid: WINDOW merge steps, one mean step and one current step on the
// shared multiplier, one output load, which waits while the previous result awaits m_tready.
// One item at a time: s_tready is low from accept until the result is loaded, and longer while the
// previous item waits for m_tready. The input rate is bounded by the one-element-per-cycle merge pass.
// Reset: window and sorted list read as zeros, zero_level is 511, no result pending.
`include "trimmed_mean_current_sensor_core_macros.svh"

module trimmed_mean_current_sensor_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [9:0] sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [9:0] filtered_level, [26:10] current_milliamp
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tmcs_pkg::LEVEL_W-1:0]  cfg_data   // zero_level
);
    import tmcs_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SORT = 3'd1;
    localparam logic [2:0] ST_MEAN = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
    localparam logic [IDX_W-1:0] LO_IDX   = IDX_W'(LO);
    localparam logic [IDX_W-1:0] HI_IDX   = IDX_W'(HI);

    logic [2:0]             state_reg;
    logic [LEVEL_W-1:0]     zero_reg;

    logic [LEVEL_W-1:0]     win_mem [WINDOW];
    logic [WINDOW-1:0]      win_valid_reg;
    logic [IDX_W-1:0]       wp_reg;
    logic [IDX_W-1:0]       wp_next;

    logic [LEVEL_W-1:0]     ring_reg [WINDOW];
    logic [LEVEL_W-1:0]     old_reg;
    logic [LEVEL_W-1:0]     buf_reg;
    logic                   rem_pending_reg;
    logic                   skip_reg;
    logic [IDX_W-1:0]       t_reg;
    logic [SUM_W-1:0]       sum_reg;

    logic [LEVEL_W-1:0]     level_reg;
    logic [MA_W-1:0]        ma_reg;
    logic                   out_valid_reg;
    logic [LEVEL_W-1:0]     out_level_reg;
    logic [MA_W-1:0]        out_ma_reg;

    logic                   in_accept;
    logic                   deliver;
    logic                   hit;
    logic                   skip_eff;
    logic                   last_t;
    logic                   a_valid;
    logic [LEVEL_W-1:0]     a_val;
    logic                   a_lt;
    logic [LEVEL_W-1:0]     push_val;
    logic [LEVEL_W-1:0]     buf_next;
    logic                   in_trim;

    logic [LEVEL_W-1:0]     diff;
    logic [SUM_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [MUL_P_W-1:0]     mul_p;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(32 - LEVEL_W - MA_W)'(0), out_ma_reg, out_level_reg};
    assign wp_next   = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
    assign deliver   = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // Merge pass: drop one copy of the evicted sample, insert the new one.
    // After the drop the next element is taken one tap further down the line.
    always_comb
    begin
        hit      = rem_pending_reg && (ring_reg[0] == old_reg);
        skip_eff = skip_reg || hit;
        last_t   = (t_reg == LAST_IDX);
        a_val    = skip_eff ? ring_reg[1] : ring_reg[0];
        a_valid  = !(skip_eff && last_t);
        a_lt     = a_valid && (a_val < buf_reg);
        push_val = a_lt ? a_val : buf_reg;
        buf_next = (a_valid && !a_lt) ? a_val : buf_reg;
        in_trim  = (t_reg >= LO_IDX) && (t_reg < HI_IDX);
    end

    // shared reciprocal multiplier: mean of the kept samples, then the mA value
    always_comb
    begin
        diff  = (level_reg >= zero_reg) ? level_reg - zero_reg : zero_reg - level_reg;
        mul_a = (state_reg == ST_MUL) ? SUM_W'(diff) : sum_reg;
        mul_b = (state_reg == ST_MUL) ? MUL_B_W'(MA_MUL) : MUL_B_W'(MEAN_MUL);
        mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    // window memory: read of the evicted slot and write of the new sample
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            win_mem[wp_next] <= s_tdata[LEVEL_W-1:0];
            old_reg          <= win_valid_reg[wp_next] ? win_mem[wp_next] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg <= ZERO_LEVEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            zero_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            win_valid_reg   <= '0;
            wp_reg          <= '0;
            buf_reg         <= '0;
            rem_pending_reg <= 1'b0;
            skip_reg        <= 1'b0;
            t_reg           <= '0;
            sum_reg         <= '0;
            level_reg       <= '0;
            ma_reg          <= '0;
            out_valid_reg   <= 1'b0;
            out_level_reg   <= '0;
            out_ma_reg      <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            if (deliver)
            begin
                out_valid_reg <= 1'b1;
                out_level_reg <= level_reg;
                out_ma_reg    <= ma_reg;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        wp_reg                 <= wp_next;
                        win_valid_reg[wp_next] <= 1'b1;
                        buf_reg                <= s_tdata[LEVEL_W-1:0];
                        rem_pending_reg        <= 1'b1;
                        skip_reg               <= 1'b0;
                        t_reg                  <= '0;
                        sum_reg                <= '0;
                        state_reg              <= ST_SORT;
                    end
                end

                ST_SORT:
                begin
                    for (int i = 0; i < WINDOW - 1; i++)
                    begin
                        ring_reg[i] <= ring_reg[i+1];
                    end
                    ring_reg[WINDOW-1] <= push_val;
                    buf_reg            <= buf_next;
                    if (hit)
                    begin
                        rem_pending_reg <= 1'b0;
                        skip_reg        <= 1'b1;
                    end
                    if (in_trim)
                    begin
                        sum_reg <= sum_reg + SUM_W'(push_val);
                    end
                    t_reg <= t_reg + 1'b1;
                    if (last_t)
                    begin
                        state_reg <= ST_MEAN;
                    end
                end

                ST_MEAN:
                begin
                    level_reg <= LEVEL_W'(mul_p >> MEAN_SHIFT);
                    state_reg <= ST_MUL;
                end

                ST_MUL:
                begin
                    ma_reg    <= MA_W'(mul_p >> MA_SHIFT);
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (deliver)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `TMCS_ASSERT_NEXT(a_accept_starts_sort, in_accept, state_reg == ST_SORT)
    `TMCS_ASSERT_IMPL(a_evicted_removed, (state_reg == ST_SORT) && last_t, !rem_pending_reg || hit)
    `TMCS_ASSERT_NEXT(a_done_delivers, deliver, out_valid_reg && (state_reg == ST_IDLE))
    `TMCS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

// ===== tb/tmcs_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the trimmed mean current sensor core: keeps its own sample window
// and zero level, predicts level and current per accepted item, compares in order.
// Depends on tmcs_pkg.
module tmcs_result_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [9:0] sample
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [31:0]                   m_tdata,   // [9:0] filtered_level, [26:10] current_milliamp
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [tmcs_pkg::LEVEL_W-1:0]  cfg_data,  // zero_level
    output int                            fail_count,
    output int                            outstanding
);

    localparam int WIN     = tmcs_pkg::WINDOW;
    localparam int LO_CUT  = (WIN * 15) / 100;
    localparam int HI_CUT  = (WIN * 85) / 100 + 1;
    localparam int KEEP_LO = (LO_CUT < 1) ? 1 : LO_CUT;
    localparam int KEEP_HI = (HI_CUT > WIN - 1) ? WIN - 1 : HI_CUT;

    localparam longint unsigned FULL_SCALE_MA = 125000;
    localparam longint unsigned ADC_COUNTS    = 1023;
    localparam logic [9:0]      ZERO_AT_RESET = 10'd511;

    typedef struct packed {
        logic [9:0]  level;
        logic [16:0] milliamp;
    } reading_t;

    logic [9:0] window_q [WIN];
    int         wr_pos;
    logic [9:0] zero_lvl;
    reading_t   readings_q [$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    // sort a copy of the window, average the middle part
    function automatic logic [9:0] trimmed_level();
        logic [9:0]  srt [WIN];
        logic [9:0]  v;
        int          a;
        int          b;
        int unsigned sum;
        srt = window_q;
        for (a = 1; a < WIN; a++)
        begin
            v = srt[a];
            b = a;
            while (b > 0 && srt[b-1] > v)
            begin
                srt[b] = srt[b-1];
                b--;
            end
            srt[b] = v;
        end
        sum = 0;
        for (a = KEEP_LO; a < KEEP_HI; a++)
            sum += srt[a];
        return 10'(sum / (KEEP_HI - KEEP_LO));
    endfunction

    function automatic logic [16:0] milliamp_of(input logic [9:0] lvl, input logic [9:0] zero);
        longint unsigned diff;
        diff = (lvl >= zero) ? longint'(lvl - zero) : longint'(zero - lvl);
        return 17'((diff * FULL_SCALE_MA) / ADC_COUNTS);
    endfunction

    always @(posedge clk)
    begin : watch
        reading_t want;
        reading_t got;
        int       i;
        if (!rst_n)
        begin
            for (i = 0; i < WIN; i++)
                window_q[i] = '0;
            wr_pos      = 0;
            zero_lvl    = ZERO_AT_RESET;
            readings_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                zero_lvl = cfg_data;

            if (m_tvalid && m_tready)
            begin
                got.level    = m_tdata[9:0];
                got.milliamp = m_tdata[26:10];
                if (readings_q.size() == 0)
                begin
                    $error("result with none pending: filtered_level %0d, current_milliamp %0d",
                           got.level, got.milliamp);
                    fail_count++;
                end
                else
                begin
                    want = readings_q.pop_front();
                    outstanding--;
                    if (got.level !== want.level)
                    begin
                        $error("filtered_level mismatch: expected %0d, actual %0d",
                               want.level, got.level);
                        fail_count++;
                    end
                    if (got.milliamp !== want.milliamp)
                    begin
                        $error("current_milliamp mismatch: expected %0d, actual %0d",
                               want.milliamp, got.milliamp);
                        fail_count++;
                    end
                end
            end

            // write position moves first, so slot 1 gets the first sample
            if (s_tvalid && s_tready)
            begin
                wr_pos           = (wr_pos + 1) % WIN;
                window_q[wr_pos] = s_tdata[9:0];
                want.level       = trimmed_level();
                want.milliamp    = milliamp_of(want.level, zero_lvl);
                readings_q.push_back(want);
                outstanding++;
            end
        end
    end

endmodule

// ===== tb/tb_trimmed_mean_current_sensor_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the trimmed mean current sensor core: clock, reset, sample and
// zero-level stimulus, receiver stalls, watchdog and verdict.
// Depends on tmcs_pkg, trimmed_mean_current_sensor_core and tmcs_result_checker.
module tb_trimmed_mean_current_sensor_core;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 100;
    localparam int PHASE_ITEMS = 280;

    typedef enum int {SPREAD, NOISY_LEVEL, FLAT_RUN, SPIKY_LEVEL} sample_style_t;

    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [15:0]                  s_tdata   = '0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [31:0]                  m_tdata;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [tmcs_pkg::LEVEL_W-1:0] cfg_data  = '0;

    int fail_count;
    int outstanding;
    int tx_idle_pct  = 27;
    int rx_idle_pct  = 60;
    bit rx_hold_req  = 1'b0;
    int quiet_cycles = 0;

    trimmed_mean_current_sensor_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tmcs_result_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_sample(input logic [9:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, value};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // sender stops until every pending result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_zero_level(input logic [9:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // bursts of similar samples so the window fills with runs, plateaus and outliers
    task automatic run_random(input int count);
        sample_style_t style;
        int            left;
        int            burst;
        int            base;
        int            v;
        int            k;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            style = sample_style_t'($urandom_range(0, 3));
            base  = $urandom_range(0, 1023);
            if (style == FLAT_RUN && $urandom_range(0, 2) != 0)
                base = ($urandom_range(0, 1) != 0) ? 1023 : 0;
            for (k = 0; k < burst && left > 0; k++)
            begin
                case (style)
                    SPREAD:      v = $urandom_range(0, 1023);
                    NOISY_LEVEL: v = base + int'($urandom_range(0, 16)) - 8;
                    FLAT_RUN:    v = base;
                    default:     v = ($urandom_range(0, 7) == 0) ?
                                     (($urandom_range(0, 1) != 0) ? 1023 : 0) : base;
                endcase
                if (v < 0)
                    v = 0;
                if (v > 1023)
                    v = 1023;
                send_sample(10'(v));
                left--;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [9:0] zero_choice [6];
        int         p;
        zero_choice[0] = 10'd0;
        zero_choice[1] = 10'd1023;
        zero_choice[2] = 10'd511;
        zero_choice[3] = 10'($urandom_range(0, 1023));
        zero_choice[4] = 10'($urandom_range(0, 1023));
        zero_choice[5] = 10'($urandom_range(0, 1023));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset zero level, window still mostly unwritten zeros
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd512);
        drain();
        // full-scale positive current
        write_zero_level(10'd0);
        repeat (16) send_sample(10'd1023);
        drain();
        write_zero_level(10'd1023);
        repeat (6) send_sample(10'd0);

        for (p = 0; p < 6; p++)
        begin
            drain();
            write_zero_level(zero_choice[p]);
            if (p < 2)
            begin
                tx_idle_pct = 27;
                rx_idle_pct = 60;
            end
            else if (p < 4)
            begin
                tx_idle_pct = 60;
                rx_idle_pct = 27;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // long receiver hold-off while samples keep coming
            if (p == 4)
                rx_hold_req = 1'b1;
            run_random(PHASE_ITEMS);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (outstanding != 0)
            $error("%0d results never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tmcs_pkg.sv
hw/rtl/trimmed_mean_current_sensor_core.sv
tb/tmcs_result_checker.sv
tb/tb_trimmed_mean_current_sensor_core.sv
